[rtl/ssfm_pkg.sv]
// shared types, constants and helpers for the seven-segment frame manager
package ssfm_pkg;

	localparam int FRAME_BYTES      = 5;
	localparam int RUN_BYTES        = 11;
	localparam int RUN_IDX_W        = $clog2(RUN_BYTES);
	localparam int QUEUE_DEPTH      = 2;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 40;
	localparam logic [31:0] BLINK_PERIOD_RST = 32'd500000;
	localparam logic [7:0]  COLON_ON  = 8'h02;
	localparam logic [7:0]  DOT_BIT   = 8'h80;
	localparam logic [7:0]  ADDR_BYTE = 8'h00;
	localparam logic [7:0]  PAD_BYTE  = 8'h00;

	typedef enum logic [2:0] {
		ACT_DIGIT  = 3'd0,
		ACT_RAW    = 3'd1,
		ACT_DOT    = 3'd2,
		ACT_COLON  = 3'd3,
		ACT_NUMBER = 3'd4,
		ACT_TICK   = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLINK_ENABLE = 2'd0,
		CFG_BLINK_MASK   = 2'd1,
		CFG_BLINK_PERIOD = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] value;
		logic [7:0]  position;
		logic        flag;
		logic [31:0] now;
	} ssfm_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} ssfm_out_t;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [7:0] seg7(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	// digits 0,1 direct, 2,3 skip the colon byte, rest land on the last byte
	function automatic logic [2:0] slot_of(input logic [7:0] pos);
		logic [2:0] s;
		priority if (pos == 8'd0 || pos == 8'd1) begin
			s = pos[2:0];
		end else if (pos == 8'd2 || pos == 8'd3) begin
			s = pos[2:0] + 3'd1;
		end else begin
			s = 3'(FRAME_BYTES - 1);
		end
		return s;
	endfunction

endpackage

[rtl/ssfm_front.sv]
// front end: input pipeline, decimal split, frame and blink state, run enqueue
module ssfm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ssfm_pkg::ssfm_in_t in_item,
	input  logic               cfg_we,
	input  logic [ssfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssfm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  ssfm_pkg::qstat_t   qstat,
	output logic               push,
	output ssfm_pkg::frame_t   push_frame
);
	import ssfm_pkg::*;

	logic     v_s1, v_s2, v_s3, v_s4;
	ssfm_in_t item_s1, item_s2, item_s3, item_s4;
	logic [13:0] n_s2;
	logic [3:0]  d3_s3, d3_s4;
	logic [9:0]  r_s3;
	logic [3:0]  d2_s4;
	logic [6:0]  r_s4;

	logic        en_q;
	frame_t      mask_q;
	logic [31:0] period_q;
	frame_t      frame_q, sent_q;
	logic        phase_q;
	logic [31:0] last_q;

	logic        advance;
	logic [2:0]  q10k;
	logic [13:0] n_c;
	logic [3:0]  d3_c, d2_c, d1_c, d0_c;
	logic [9:0]  r1000_c;
	logic [6:0]  r100_c;
	logic        is_tick, toggle, phase_n, need_run;
	logic [31:0] elapsed;
	frame_t      shown;

	// value mod 10000 by constant compares
	always_comb begin
		q10k = 3'd0;
		for (int k = 1; k <= 6; k++) begin
			if (item_s1.value >= 16'(k * 10000)) q10k = 3'(k);
		end
		n_c = 14'(item_s1.value - 16'(q10k) * 16'd10000);
	end

	always_comb begin
		d3_c = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (n_s2 >= 14'(k * 1000)) d3_c = 4'(k);
		end
		r1000_c = 10'(n_s2 - 14'(d3_c) * 14'd1000);
	end

	always_comb begin
		d2_c = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (r_s3 >= 10'(k * 100)) d2_c = 4'(k);
		end
		r100_c = 7'(r_s3 - 10'(d2_c) * 10'd100);
	end

	always_comb begin
		d1_c = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (r_s4 >= 7'(k * 10)) d1_c = 4'(k);
		end
		d0_c = 4'(r_s4 - 7'(d1_c) * 7'd10);
	end

	// blink and change detection at the commit stage
	always_comb begin
		is_tick = (item_s4.action == ACT_TICK);
		elapsed = item_s4.now - last_q;
		toggle  = en_q && (elapsed >= period_q);
		phase_n = phase_q ^ toggle;
		shown   = (en_q && phase_n) ? (frame_q & ~mask_q) : frame_q;
		need_run = v_s4 && is_tick && (shown != sent_q);
	end

	assign advance    = !(need_run && qstat.full);
	assign in_stall   = !advance;
	assign push       = need_run && advance;
	assign push_frame = shown;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= in_item;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			n_s2    <= n_c;
			d3_s3   <= d3_c;
			r_s3    <= r1000_c;
			d3_s4   <= d3_s3;
			d2_s4   <= d2_c;
			r_s4    <= r100_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			mask_q   <= '0;
			period_q <= BLINK_PERIOD_RST;
			frame_q  <= '0;
			sent_q   <= '0;
			phase_q  <= 1'b0;
			last_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BLINK_ENABLE: en_q     <= cfg_data[0];
					CFG_BLINK_MASK:   mask_q   <= cfg_data;
					CFG_BLINK_PERIOD: period_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (v_s4 && advance) begin
				unique case (item_s4.action)
					ACT_DIGIT: frame_q[slot_of(item_s4.position)] <= seg7(d0_c);
					ACT_RAW:   frame_q[slot_of(item_s4.position)] <= item_s4.value[7:0];
					ACT_DOT: begin
						if (item_s4.flag) begin
							frame_q[slot_of(item_s4.position)] <=
								frame_q[slot_of(item_s4.position)] | DOT_BIT;
						end else begin
							frame_q[slot_of(item_s4.position)] <=
								frame_q[slot_of(item_s4.position)] & ~DOT_BIT;
						end
					end
					ACT_COLON: frame_q[2] <= item_s4.flag ? COLON_ON : 8'h00;
					ACT_NUMBER: begin
						frame_q[0] <= seg7(d3_s4);
						frame_q[1] <= seg7(d2_s4);
						frame_q[3] <= seg7(d1_c);
						frame_q[4] <= seg7(d0_c);
					end
					ACT_TICK: begin
						if (toggle) begin
							phase_q <= phase_n;
							last_q  <= item_s4.now;
						end
						if (need_run) sent_q <= shown;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

[rtl/ssfm_queue.sv]
// small fifo of frames waiting to be sent
module ssfm_queue #(
	parameter int Depth = ssfm_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ssfm_pkg::frame_t push_frame,
	input  logic             pop,
	output ssfm_pkg::frame_t head,
	output ssfm_pkg::qstat_t qstat
);
	import ssfm_pkg::*;

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	frame_t          mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = (cnt_q == CntW'(Depth));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/ssfm_back.sv]
// back end: serializes one frame into the eleven-byte run
module ssfm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ssfm_pkg::qstat_t  qstat,
	input  ssfm_pkg::frame_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output ssfm_pkg::ssfm_out_t out_item
);
	import ssfm_pkg::*;

	logic                 busy_q;
	logic [RUN_IDX_W-1:0] idx_q;
	frame_t               run_q;
	logic                 take, done;

	assign take = busy_q && !out_stall;
	assign done = take && (idx_q == RUN_IDX_W'(RUN_BYTES - 1));
	assign pop  = (!busy_q || done) && !qstat.empty;

	assign out_valid = busy_q;
	// address byte, then each frame byte followed by a pad byte
	assign out_item.out_byte = (idx_q == '0) ? ADDR_BYTE :
		(idx_q[0] ? run_q[idx_q[RUN_IDX_W-1:1]] : PAD_BYTE);
	assign out_item.last = (idx_q == RUN_IDX_W'(RUN_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) run_q <= head;
	end

endmodule

[rtl/seven_segment_frame_manager_unit.sv]
// top level of the seven-segment frame manager
//
// Input channel (in_valid / in_stall / in_item) takes one command item per cycle
// while in_stall is low: digit, raw segments, dot, colon, number or tick. Items
// pass a four-stage front pipeline that splits numbers into decimal digits and
// commits to the frame at the last stage. Draw commands give no item out.
// A tick whose shown frame differs from the last one sent queues that frame;
// the back end sends it as eleven items (address byte, then data/pad pairs),
// one per cycle on out_valid / out_stall / out_item unless out_stall is high,
// last set on the eleventh. Input items are taken one per cycle unless stalled,
// and a changed tick occupies the output for its whole run; the queue of frames
// is the only coupling between the two sides.
// When the receiver stalls, the current byte holds; input stalls only when the
// queue is full and a tick at the commit stage needs a slot.
// Configuration (cfg_valid / cfg_ready, always ready) sets blink enable, mask
// and period. Reset clears frame, sent frame, blink phase and toggle time and
// empties the queue; the period resets to 500000.
module seven_segment_frame_manager_unit #(
	parameter int QueueDepth = ssfm_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ssfm_pkg::ssfm_in_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ssfm_pkg::ssfm_out_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ssfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssfm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ssfm_pkg::*;

	qstat_t qstat;
	logic   push, pop;
	frame_t push_frame, head;

	assign cfg_ready = 1'b1;

	ssfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.push       (push),
		.push_frame (push_frame)
	);

	ssfm_queue #(.Depth(QueueDepth)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	ssfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qstat.full || pop))
		else $error("frame queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty frame queue");

	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_item.last) |=>
		(!out_valid || (out_item.out_byte == ADDR_BYTE && !out_item.last)))
		else $error("run does not restart at the address byte");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> qstat.full)
		else $error("input stalled with room in the queue");

endmodule

[test/seven_segment_frame_manager_unit_tb.sv]
// self-checking testbench for the seven-segment frame manager: frame prediction and byte runs
`timescale 1ns / 100ps

module seven_segment_frame_manager_unit_tb;
	import ssfm_pkg::*;

	localparam logic [1:0] CFG_SPARE   = 2'd3;
	localparam logic [2:0] ACT_SPARE0  = 3'd6;
	localparam logic [2:0] ACT_SPARE1  = 3'd7;
	localparam int         QUIET_LIMIT = 4000;
	localparam int         SETTLE      = 12;
	localparam int         REPORT_MAX  = 10;

	// predicts the frame, blink phase and the byte runs that ticks send
	class frame_scoreboard;
		logic            blink_on;
		logic [39:0]     blink_bits;
		logic [31:0]     period;
		frame_t          frame;
		frame_t          sent;
		logic            phase;
		logic [31:0]     toggled_at;
		ssfm_out_t       expected_bytes[$];
		int              failures;

		function new();
			blink_on   = 1'b0;
			blink_bits = '0;
			period     = BLINK_PERIOD_RST;
			frame      = '0;
			sent       = '0;
			phase      = 1'b0;
			toggled_at = '0;
			failures   = 0;
		endfunction

		function logic [7:0] digit_segments(int d);
			case (d)
				0: return 8'h3F;
				1: return 8'h06;
				2: return 8'h5B;
				3: return 8'h4F;
				4: return 8'h66;
				5: return 8'h6D;
				6: return 8'h7D;
				7: return 8'h07;
				8: return 8'h7F;
				default: return 8'h6F;
			endcase
		endfunction

		// positions 2,3 step over the colon byte
		function int byte_slot(logic [7:0] pos);
			if (pos < 8'd2) return int'(pos);
			if (pos < 8'd4) return int'(pos) + 1;
			return FRAME_BYTES - 1;
		endfunction

		function void set_reg(logic [1:0] idx, logic [39:0] data);
			case (idx)
				CFG_BLINK_ENABLE: blink_on = data[0];
				CFG_BLINK_MASK:   blink_bits = data;
				CFG_BLINK_PERIOD: period = data[31:0];
				default: ;
			endcase
		endfunction

		function void absorb_command(ssfm_in_t it);
			int          n;
			int          s;
			logic [31:0] elapsed;
			frame_t      shown;
			n = int'(it.value) % 10000;
			s = byte_slot(it.position);
			case (it.action)
				ACT_DIGIT: frame[s] = digit_segments(int'(it.value) % 10);
				ACT_RAW:   frame[s] = it.value[7:0];
				ACT_DOT:   frame[s] = it.flag ? (frame[s] | DOT_BIT) : (frame[s] & ~DOT_BIT);
				ACT_COLON: frame[2] = it.flag ? COLON_ON : 8'h00;
				ACT_NUMBER: begin
					frame[0] = digit_segments(n / 1000);
					frame[1] = digit_segments((n % 1000) / 100);
					frame[3] = digit_segments((n % 100) / 10);
					frame[4] = digit_segments(n % 10);
				end
				ACT_TICK: begin
					elapsed = it.now - toggled_at;
					if (blink_on && elapsed >= period) begin
						toggled_at = it.now;
						phase      = ~phase;
					end
					shown = frame;
					if (blink_on && phase) begin
						for (int i = 0; i < FRAME_BYTES; i++)
							shown[i] = shown[i] & ~blink_bits[8*i +: 8];
					end
					if (shown != sent) begin
						sent = shown;
						expected_bytes.push_back('{out_byte: ADDR_BYTE, last: 1'b0});
						for (int i = 0; i < FRAME_BYTES; i++) begin
							expected_bytes.push_back('{out_byte: shown[i], last: 1'b0});
							expected_bytes.push_back('{out_byte: PAD_BYTE,
								last: (i == FRAME_BYTES - 1)});
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void report(string what, ssfm_out_t want, ssfm_out_t got);
			failures++;
			if (failures <= REPORT_MAX)
				$display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
					$time, what, want.out_byte, want.last, got.out_byte, got.last);
		endfunction

		function void compare_byte(ssfm_out_t got);
			ssfm_out_t want;
			if (expected_bytes.size() == 0) begin
				report("byte with nothing pending", '0, got);
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.last !== want.last)
				report("byte mismatch", want, got);
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	ssfm_in_t                in_item   = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	ssfm_out_t               out_item;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;

	frame_scoreboard sb;
	int              send_idle = 26;
	int              recv_idle = 47;
	logic [31:0]     wall = '0;

	seven_segment_frame_manager_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver side: check each accepted byte, then pick the next stall
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall == 1'b0)
			sb.compare_byte(out_item);
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// watchdog on cycles with no handshake at all
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
				(cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic ssfm_in_t pack_cmd(logic [2:0] act, logic [15:0] val,
		logic [7:0] pos, logic fl, logic [31:0] stamp);
		ssfm_in_t it;
		it.action   = act;
		it.value    = val;
		it.position = pos;
		it.flag     = fl;
		it.now      = stamp;
		return it;
	endfunction

	function automatic ssfm_in_t random_command();
		ssfm_in_t    it;
		int          pick;
		logic [31:0] step_max;
		it = pack_cmd(3'($urandom_range(4)), 16'($urandom), 8'($urandom),
			1'($urandom), $urandom);
		pick = $urandom_range(99);
		if (pick < 3) begin
			it.action = $urandom_range(1) ? ACT_SPARE0 : ACT_SPARE1;
		end else if (pick < 33) begin
			it.action = ACT_TICK;
			step_max  = sb.period[31] ? 32'hFFFF_FFFF : {sb.period[30:0], 1'b0};
			case ($urandom_range(15))
				0: wall = $urandom;
				1: wall = sb.toggled_at + sb.period;
				2: wall = sb.toggled_at + sb.period - 32'd1;
				default: wall = wall + $urandom_range(step_max);
			endcase
			it.now = wall;
		end else begin
			if ($urandom_range(9) < 8)
				it.position = 8'($urandom_range(3));
			if (it.action == ACT_DIGIT && $urandom_range(3) != 0)
				it.value = 16'($urandom_range(9));
		end
		return it;
	endfunction

	task automatic send_command(ssfm_in_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.absorb_command(it);
	endtask

	// sender holds off until every pending byte has arrived
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// draws and ticks without bytes may still sit in the front pipeline
	task automatic run_phase(logic en, logic [39:0] mask, logic [31:0] per, int count);
		ssfm_in_t it;
		int       done;
		drain();
		repeat (SETTLE) @(posedge clk);
		write_reg(CFG_SPARE, {8'($urandom), $urandom});
		write_reg(CFG_BLINK_ENABLE, 40'(en));
		write_reg(CFG_BLINK_MASK, mask);
		write_reg(CFG_BLINK_PERIOD, 40'(per));
		cfg_valid <= 1'b0;
		wall = sb.toggled_at;
		done = 0;
		while (done < count) begin
			it = random_command();
			send_command(it);
			if (it.action <= ACT_TICK)
				done++;
			if (done == count / 2 && it.action == ACT_TICK)
				drain();
		end
	endtask

	initial begin
		ssfm_in_t directed[$];
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(pack_cmd(ACT_TICK, 16'h0000, 8'd0, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_DIGIT, 16'hFFFF, 8'd0, 1'b0, 32'hFFFF_FFFF));
		directed.push_back(pack_cmd(ACT_DIGIT, 16'd9, 8'd1, 1'b1, 32'd0));
		directed.push_back(pack_cmd(ACT_DIGIT, 16'd0, 8'd2, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_DIGIT, 16'd8, 8'd3, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_DIGIT, 16'd7, 8'd255, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_RAW, 16'hFFFF, 8'd4, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_RAW, 16'hAA00, 8'd0, 1'b1, 32'd0));
		directed.push_back(pack_cmd(ACT_DOT, 16'd0, 8'd1, 1'b1, 32'd0));
		directed.push_back(pack_cmd(ACT_DOT, 16'hFFFF, 8'd255, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_DOT, 16'd0, 8'd2, 1'b1, 32'd0));
		directed.push_back(pack_cmd(ACT_COLON, 16'd0, 8'd200, 1'b1, 32'd0));
		directed.push_back(pack_cmd(ACT_TICK, 16'd0, 8'd0, 1'b0, 32'hFFFF_FFFF));
		directed.push_back(pack_cmd(ACT_TICK, 16'd0, 8'd0, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_NUMBER, 16'd9999, 8'd3, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_TICK, 16'd0, 8'd0, 1'b0, 32'd5));
		directed.push_back(pack_cmd(ACT_NUMBER, 16'hFFFF, 8'd0, 1'b1, 32'd0));
		directed.push_back(pack_cmd(ACT_TICK, 16'hFFFF, 8'd255, 1'b1, 32'd9));
		directed.push_back(pack_cmd(ACT_COLON, 16'hFFFF, 8'd0, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_NUMBER, 16'd0, 8'd0, 1'b0, 32'd0));
		directed.push_back(pack_cmd(ACT_SPARE0, 16'h1234, 8'd1, 1'b1, 32'd7));
		directed.push_back(pack_cmd(ACT_SPARE1, 16'hFFFF, 8'd255, 1'b1, $urandom));
		directed.push_back(pack_cmd(ACT_TICK, 16'd0, 8'd0, 1'b0, 32'd11));
		foreach (directed[i])
			send_command(directed[i]);

		run_phase(1'b1, 40'hFF_FFFF_FFFF, 32'd1, 58);
		run_phase(1'b1, {8'($urandom), $urandom}, 32'($urandom_range(50, 10)), 58);
		send_idle = 47;
		recv_idle = 26;
		run_phase(1'b1, 40'h00_0000_0000, 32'hFFFF_FFFF, 58);
		run_phase(1'b0, {8'($urandom), $urandom}, BLINK_PERIOD_RST, 58);
		send_idle = 0;
		recv_idle = 0;
		run_phase(1'b1, {8'($urandom), $urandom}, 32'd0, 58);
		run_phase(1'b1, {8'($urandom), $urandom}, 32'($urandom_range(200, 20)), 58);

		drain();
		repeat (2 * SETTLE) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
rtl/ssfm_pkg.sv
rtl/ssfm_front.sv
rtl/ssfm_queue.sv
rtl/ssfm_back.sv
rtl/seven_segment_frame_manager_unit.sv
test/seven_segment_frame_manager_unit_tb.sv
